FILE: rtl/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared constants, command codes and pipeline control types of the 4x4
// fixed-point row multiplier.
// ----------------------------------------------------------------------------
package mrm_pkg;

   localparam int DIM_DEF        = 4;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ELEM_WIDTH_DEF = 32;

   // Element fields carried by one request and one response row.
   localparam int LANES         = 4;
   localparam int ROW_SEL_WIDTH = 2;

   typedef enum logic {
      CMD_LOAD     = 1'b0,
      CMD_MULTIPLY = 1'b1
   } cmd_type;

   // Control into the multiply stage.
   typedef struct packed {
      logic adv;
      logic valid;
   } mul_ctl_type;

   // Advance strobes into the adder tree.
   typedef struct packed {
      logic pair_adv;
      logic total_adv;
   } sum_ctl_type;

   // Occupancy of the adder tree registers.
   typedef struct packed {
      logic pair_valid;
      logic total_valid;
   } sum_sts_type;

endpackage

FILE: rtl/mrm_req_if.sv
// ----------------------------------------------------------------------------
// mrm_req_if
// Request channel: command, right-matrix row select and four row elements.
// ----------------------------------------------------------------------------
interface mrm_req_if #(
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
);
   import mrm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [ROW_SEL_WIDTH-1:0]     row_sel;
   logic signed [ELEM_WIDTH-1:0] elem_0;
   logic signed [ELEM_WIDTH-1:0] elem_1;
   logic signed [ELEM_WIDTH-1:0] elem_2;
   logic signed [ELEM_WIDTH-1:0] elem_3;

   modport source (
      output valid, cmd, row_sel, elem_0, elem_1, elem_2, elem_3,
      input  ready
   );

   modport sink (
      input  valid, cmd, row_sel, elem_0, elem_1, elem_2, elem_3,
      output ready
   );

endinterface

FILE: rtl/mrm_rsp_if.sv
// ----------------------------------------------------------------------------
// mrm_rsp_if
// Response channel: one saturated product row and its overflow flag.
// ----------------------------------------------------------------------------
interface mrm_rsp_if #(
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
);
   import mrm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] prod_0;
   logic signed [ELEM_WIDTH-1:0] prod_1;
   logic signed [ELEM_WIDTH-1:0] prod_2;
   logic signed [ELEM_WIDTH-1:0] prod_3;
   logic                         overflow;

   modport source (
      output valid, prod_0, prod_1, prod_2, prod_3, overflow,
      input  ready
   );

   modport sink (
      input  valid, prod_0, prod_1, prod_2, prod_3, overflow,
      output ready
   );

endinterface

FILE: rtl/mrm_mul_stage.sv
// ----------------------------------------------------------------------------
// mrm_mul_stage
// Right-matrix store and the array of element multipliers; one register
// stage of full-precision products.
// ----------------------------------------------------------------------------
module mrm_mul_stage #(
   parameter int DIM        = mrm_pkg::DIM_DEF,
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mrm_pkg::mul_ctl_type                ctl,
   input  mrm_pkg::cmd_type                    cmd,
   input  logic [mrm_pkg::ROW_SEL_WIDTH-1:0]   row_sel,
   input  logic signed [ELEM_WIDTH-1:0]        elem [mrm_pkg::LANES],
   output logic                                prod_valid_ff,
   output logic signed [2*ELEM_WIDTH-1:0]      prod_ff [mrm_pkg::LANES][mrm_pkg::LANES]
);
   import mrm_pkg::*;

   localparam int USED = (DIM < LANES) ? DIM : LANES;
   localparam int PW   = 2 * ELEM_WIDTH;

   // store_ff[row][col]
   logic signed [ELEM_WIDTH-1:0] store_ff [USED][USED];
   logic signed [PW-1:0]         prod_in  [LANES][LANES];
   logic                         prod_valid_in;
   logic                         load_wr;

   // write a load row as it leaves the input register
   assign load_wr       = ctl.valid && (cmd == CMD_LOAD) && ctl.adv;
   assign prod_valid_in = ctl.valid && (cmd == CMD_MULTIPLY);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < USED; r++) begin
            for (int c = 0; c < USED; c++) begin
               store_ff[r][c] <= '0;
            end
         end
      end else if (load_wr) begin
         for (int r = 0; r < USED; r++) begin
            if (ROW_SEL_WIDTH'(r) == row_sel) begin
               for (int c = 0; c < USED; c++) begin
                  store_ff[r][c] <= elem[c];
               end
            end
         end
      end
   end

   // product [col][k] = left[k] * right[k][col]
   for (genvar c = 0; c < LANES; c++) begin : g_col
      for (genvar k = 0; k < LANES; k++) begin : g_term
         if ((c < USED) && (k < USED)) begin : g_mul
            assign prod_in[c][k] = elem[k] * store_ff[k][c];
         end else begin : g_zero
            assign prod_in[c][k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (ctl.adv) begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: rtl/mrm_sum_stage.sv
// ----------------------------------------------------------------------------
// mrm_sum_stage
// Two-level registered adder tree: pair sums, then the exact column total.
// ----------------------------------------------------------------------------
module mrm_sum_stage #(
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mrm_pkg::sum_ctl_type               ctl,
   input  logic                               prod_valid,
   input  logic signed [2*ELEM_WIDTH-1:0]     prod [mrm_pkg::LANES][mrm_pkg::LANES],
   output mrm_pkg::sum_sts_type               sts,
   output logic signed [2*ELEM_WIDTH+1:0]     total_ff [mrm_pkg::LANES]
);
   import mrm_pkg::*;

   localparam int PW    = 2 * ELEM_WIDTH;
   localparam int PAIRS = LANES / 2;

   logic signed [PW:0]   pair_in  [LANES][PAIRS];
   logic signed [PW:0]   pair_ff  [LANES][PAIRS];
   logic signed [PW+1:0] total_in [LANES];
   logic                 pair_valid_ff;
   logic                 total_valid_ff;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         for (int h = 0; h < PAIRS; h++) begin
            pair_in[c][h] = prod[c][2*h] + prod[c][2*h+1];
         end
         total_in[c] = pair_ff[c][0] + pair_ff[c][1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff  <= 1'b0;
         total_valid_ff <= 1'b0;
      end else begin
         if (ctl.pair_adv) begin
            pair_valid_ff <= prod_valid;
         end
         if (ctl.total_adv) begin
            total_valid_ff <= pair_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pair_adv) begin
         pair_ff <= pair_in;
      end
      if (ctl.total_adv) begin
         total_ff <= total_in;
      end
   end

   assign sts.pair_valid  = pair_valid_ff;
   assign sts.total_valid = total_valid_ff;

endmodule

FILE: rtl/mrm_sat_stage.sv
// ----------------------------------------------------------------------------
// mrm_sat_stage
// Arithmetic shift by the fraction bits, saturation to the element width,
// and the response output register.
// ----------------------------------------------------------------------------
module mrm_sat_stage #(
   parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF,
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             total_valid,
   input  logic signed [2*ELEM_WIDTH+1:0]   total [mrm_pkg::LANES],
   output logic                             out_valid_ff,
   output logic signed [ELEM_WIDTH-1:0]     out_prod_ff [mrm_pkg::LANES],
   output logic                             out_ovf_ff
);
   import mrm_pkg::*;

   localparam int SW = 2 * ELEM_WIDTH + 2;
   localparam logic [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   logic signed [SW-1:0]         shifted     [LANES];
   logic signed [ELEM_WIDTH-1:0] out_prod_in [LANES];
   logic [LANES-1:0]             clip;
   logic                         out_ovf_in;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         shifted[c] = total[c] >>> FRAC_BITS;
         // in range when every bit from the element sign upward agrees
         clip[c] = !((&shifted[c][SW-1:ELEM_WIDTH-1]) || !(|shifted[c][SW-1:ELEM_WIDTH-1]));
         if (!clip[c]) begin
            out_prod_in[c] = shifted[c][ELEM_WIDTH-1:0];
         end else if (shifted[c][SW-1]) begin
            out_prod_in[c] = SAT_MIN;
         end else begin
            out_prod_in[c] = SAT_MAX;
         end
      end
      out_ovf_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= total_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_prod_ff <= out_prod_in;
         out_ovf_ff  <= out_ovf_in;
      end
   end

endmodule

FILE: rtl/mat4_row_multiply.sv
// ----------------------------------------------------------------------------
// mat4_row_multiply
// Signed fixed-point 4x4 matrix product, one left-matrix row per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries requests. cmd = load writes elem_0..elem_3 into row
//   row_sel of the stored right matrix and returns nothing; cmd = multiply
//   takes elem_0..elem_3 as a left-matrix row and returns the product row on
//   rsp_bus, each column saturated to the element width, with overflow set
//   when any column clipped. Loads and multiplies keep their order, so a
//   multiply sees every load accepted before it.
//   A multiply accepted into the input register passes the multiplier,
//   pair adder and column total registers, then shows on rsp_bus from the
//   shift/saturate output register.
//   Throughput: one request per cycle while rsp_bus takes rows; the sixteen
//   element multipliers share one register stage, each tree level has its own.
//   Reset clears all stage valid bits and zeroes the right-matrix store in
//   the same cycle; req_bus.ready is high once reset is released.
//   When rsp_bus stalls, the output register holds its row and empty stages
//   behind it keep filling; req_bus.ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module mat4_row_multiply #(
   parameter int DIM        = mrm_pkg::DIM_DEF,
   parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF,
   parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mrm_req_if.sink   req_bus,
   mrm_rsp_if.source rsp_bus
);
   import mrm_pkg::*;

   localparam int PW = 2 * ELEM_WIDTH;
   localparam logic [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   // input register
   logic                         req_valid_ff;
   cmd_type                      cmd_ff;
   logic [ROW_SEL_WIDTH-1:0]     row_sel_ff;
   logic signed [ELEM_WIDTH-1:0] elem_ff [LANES];

   // stage advance strobes, output end first
   logic adv_out;
   logic adv_total;
   logic adv_pair;
   logic adv_mul;
   logic adv_in;

   mul_ctl_type                  mul_ctl;
   sum_ctl_type                  sum_ctl;
   sum_sts_type                  sum_sts;
   logic                         prod_valid;
   logic signed [PW-1:0]         prod [LANES][LANES];
   logic signed [PW+1:0]         total [LANES];
   logic                         out_valid;
   logic signed [ELEM_WIDTH-1:0] out_prod [LANES];
   logic                         out_ovf;

   // a stage moves when it is empty or the stage after it moves
   assign adv_out   = !out_valid || rsp_bus.ready;
   assign adv_total = !sum_sts.total_valid || adv_out;
   assign adv_pair  = !sum_sts.pair_valid || adv_total;
   assign adv_mul   = !prod_valid || adv_pair;
   assign adv_in    = !req_valid_ff || adv_mul;

   assign req_bus.ready = adv_in;

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (adv_in) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_bus.valid) begin
         cmd_ff     <= cmd_type'(req_bus.cmd);
         row_sel_ff <= req_bus.row_sel;
         elem_ff[0] <= req_bus.elem_0;
         elem_ff[1] <= req_bus.elem_1;
         elem_ff[2] <= req_bus.elem_2;
         elem_ff[3] <= req_bus.elem_3;
      end
   end

   assign mul_ctl.adv   = adv_mul;
   assign mul_ctl.valid = req_valid_ff;

   mrm_mul_stage #(
      .DIM        (DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mul (
      .clock         (clock),
      .reset         (reset),
      .ctl           (mul_ctl),
      .cmd           (cmd_ff),
      .row_sel       (row_sel_ff),
      .elem          (elem_ff),
      .prod_valid_ff (prod_valid),
      .prod_ff       (prod)
   );

   assign sum_ctl.pair_adv  = adv_pair;
   assign sum_ctl.total_adv = adv_total;

   mrm_sum_stage #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_sum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sum_ctl),
      .prod_valid (prod_valid),
      .prod       (prod),
      .sts        (sum_sts),
      .total_ff   (total)
   );

   mrm_sat_stage #(
      .FRAC_BITS  (FRAC_BITS),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_sat (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv_out),
      .total_valid  (sum_sts.total_valid),
      .total        (total),
      .out_valid_ff (out_valid),
      .out_prod_ff  (out_prod),
      .out_ovf_ff   (out_ovf)
   );

   // drive the response channel straight from the output register
   assign rsp_bus.valid    = out_valid;
   assign rsp_bus.prod_0   = out_prod[0];
   assign rsp_bus.prod_1   = out_prod[1];
   assign rsp_bus.prod_2   = out_prod[2];
   assign rsp_bus.prod_3   = out_prod[3];
   assign rsp_bus.overflow = out_ovf;

`ifndef SYNTHESIS
   // a multiply leaving the input register lands in the product stage
   a_mul_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && (cmd_ff == CMD_MULTIPLY) && adv_mul) |=> prod_valid)
      else $error("multiply request lost at product stage");

   // a load updates the store only and never travels on
   a_load_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && (cmd_ff == CMD_LOAD) && adv_mul) |=> !prod_valid)
      else $error("load request reached product stage");

   // a flagged row carries at least one clipped column
   a_ovf_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.overflow) |->
         (rsp_bus.prod_0 == SAT_MAX || rsp_bus.prod_0 == SAT_MIN ||
          rsp_bus.prod_1 == SAT_MAX || rsp_bus.prod_1 == SAT_MIN ||
          rsp_bus.prod_2 == SAT_MAX || rsp_bus.prod_2 == SAT_MIN ||
          rsp_bus.prod_3 == SAT_MAX || rsp_bus.prod_3 == SAT_MIN))
      else $error("overflow without a saturated column");

   // reset empties the pipeline at once
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_bus.valid && !prod_valid && !req_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

FILE: verif/mat4_row_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat4_row_multiply_tb
// Self-checking bench for the fixed-point row multiplier. A short table of
// requests covers reset contents, identity, saturation and floor rounding.
// Random loads and multiplies follow over several handshake-pressure phases.
// Every product row is compared with a typed row or a local model of the matrix.
// ----------------------------------------------------------------------------
module mat4_row_multiply_tb;
   import mrm_pkg::*;

   localparam int W    = ELEM_WIDTH_DEF;
   localparam int FRAC = FRAC_BITS_DEF;
   localparam int SW   = 2 * W + 2;

   localparam int RANDOM_ITEMS  = 1630;
   localparam int PHASES        = 5;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DIRECTED_ROWS = 22;
   localparam int SMALL_SPAN    = 1 << 18;
   localparam int LOAD_PCT      = 30;

   // Q16.16 values used by the table and the random mix.
   localparam logic [W-1:0] Q_ZERO    = '0;
   localparam logic [W-1:0] Q_LSB     = W'(1);
   localparam logic [W-1:0] Q_NEG1    = '1;
   localparam logic [W-1:0] Q_ONE     = W'(1) << FRAC;
   localparam logic [W-1:0] Q_NEG_ONE = -(W'(1) << FRAC);
   localparam logic [W-1:0] Q_HALF    = W'(1) << (FRAC - 1);
   localparam logic [W-1:0] Q_MAX     = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] Q_MIN     = {1'b1, {(W-1){1'b0}}};

   // Saturation bounds at the width of the exact column sum.
   localparam logic signed [SW-1:0] SUM_MAX = $signed({{(W+3){1'b0}}, {(W-1){1'b1}}});
   localparam logic signed [SW-1:0] SUM_MIN = $signed({{(W+3){1'b1}}, {(W-1){1'b0}}});

   typedef struct packed {
      cmd_type                cmd;
      logic [1:0]             row_sel;
      logic [0:3][W-1:0]      elem;
   } request_type;

   typedef struct packed {
      logic [0:3][W-1:0]      prod;
      logic                   overflow;
   } product_row_type;

   typedef struct packed {
      request_type            rq;
      logic                   typed;
      product_row_type        want;
   } stim_row_type;

   localparam product_row_type NO_ROW = '0;

   logic clock;
   logic reset;

   int   error_count   = 0;
   int   cycle_count   = 0;
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   logic hold_off_go   = 1'b0;

   // Local copy of the right-hand matrix, row-major, and the rows still owed.
   logic [0:3][0:3][W-1:0] right_rows;
   product_row_type        expected_rows[$];

   mrm_req_if #(.ELEM_WIDTH(W)) req_ch ();
   mrm_rsp_if #(.ELEM_WIDTH(W)) rsp_ch ();

   mat4_row_multiply #(
      .DIM        (DIM_DEF),
      .FRAC_BITS  (FRAC),
      .ELEM_WIDTH (W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Directed requests. Only results that are obvious carry a typed row;
   // the rest go through the model.
   stim_row_type stim_table [DIRECTED_ROWS] = '{
      // store is all zero after reset
      '{'{CMD_MULTIPLY, 2'd0, '{Q_MAX, Q_MIN, Q_NEG1, Q_LSB}}, 1'b1,
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0}},
      // load the identity
      '{'{CMD_LOAD, 2'd0, '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd1, '{Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd2, '{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd3, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE}}, 1'b0, NO_ROW},
      // identity passes the row through untouched
      '{'{CMD_MULTIPLY, 2'd1, '{Q_MAX, Q_MIN, Q_NEG1, Q_LSB}}, 1'b1,
        '{'{Q_MAX, Q_MIN, Q_NEG1, Q_LSB}, 1'b0}},
      '{'{CMD_MULTIPLY, 2'd2, '{Q_ONE, Q_NEG_ONE, Q_HALF, Q_ZERO}}, 1'b0, NO_ROW},
      // fill every entry with the largest value
      '{'{CMD_LOAD, 2'd0, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd1, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd2, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd3, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}}, 1'b0, NO_ROW},
      // positive and negative saturation on every column
      '{'{CMD_MULTIPLY, 2'd3, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}}, 1'b1,
        '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1}},
      '{'{CMD_MULTIPLY, 2'd0, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}}, 1'b1,
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1}},
      '{'{CMD_MULTIPLY, 2'd0, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b1,
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0}},
      // shift rounds toward minus infinity
      '{'{CMD_MULTIPLY, 2'd0, '{Q_NEG1, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b0, NO_ROW},
      '{'{CMD_MULTIPLY, 2'd0, '{Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b0, NO_ROW},
      // most negative times itself clips high
      '{'{CMD_LOAD, 2'd0, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}}, 1'b0, NO_ROW},
      '{'{CMD_MULTIPLY, 2'd0, '{Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b1,
        '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1}},
      // exactly at the negative bound, no clip
      '{'{CMD_MULTIPLY, 2'd0, '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}}, 1'b0, NO_ROW},
      '{'{CMD_LOAD, 2'd2, '{32'h1234_5678, 32'hEDCB_A987, Q_LSB, Q_NEG1}}, 1'b0, NO_ROW},
      '{'{CMD_MULTIPLY, 2'd3, '{32'h0002_0000, 32'hFFFE_0000, Q_ONE, 32'h7FFF_0000}},
        1'b0, NO_ROW},
      '{'{CMD_MULTIPLY, 2'd1, '{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO}}, 1'b0, NO_ROW}
   };

   // Exact column sums, arithmetic shift, then clip to the element width.
   function automatic product_row_type predict_product_row(input logic [0:3][W-1:0] left);
      product_row_type      row;
      logic signed [SW-1:0] acc;
      logic signed [SW-1:0] a;
      logic signed [SW-1:0] b;
      row = '0;
      for (int c = 0; c < LANES; c++) begin
         acc = '0;
         for (int k = 0; k < LANES; k++) begin
            a   = $signed(left[k]);
            b   = $signed(right_rows[k][c]);
            acc = acc + a * b;
         end
         acc = acc >>> FRAC;
         if (acc > SUM_MAX) begin
            row.prod[c]  = SUM_MAX[W-1:0];
            row.overflow = 1'b1;
         end else if (acc < SUM_MIN) begin
            row.prod[c]  = SUM_MIN[W-1:0];
            row.overflow = 1'b1;
         end else begin
            row.prod[c] = acc[W-1:0];
         end
      end
      return row;
   endfunction

   // Offer one request after a random idle gap, hold it until accepted,
   // then update the matrix copy or queue the product row it owes.
   task automatic apply_request(input request_type rq, input logic typed,
                                input product_row_type want);
      product_row_type owed;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= rq.cmd;
      req_ch.row_sel <= rq.row_sel;
      req_ch.elem_0  <= rq.elem[0];
      req_ch.elem_1  <= rq.elem[1];
      req_ch.elem_2  <= rq.elem[2];
      req_ch.elem_3  <= rq.elem[3];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (rq.cmd == CMD_LOAD) begin
         right_rows[rq.row_sel] = rq.elem;
      end else begin
         owed          = typed ? want : predict_product_row(rq.elem);
         expected_rows = {expected_rows, owed};
      end
      @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off counted here so
   // the pipeline fills and back-pressures the request side.
   initial begin : rsp_receiver
      int   hold_left;
      logic hold_used;
      hold_left    = 0;
      hold_used    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted product row with the oldest one owed.
   always @(posedge clock) begin : product_checker
      product_row_type got;
      product_row_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.prod     = {rsp_ch.prod_0, rsp_ch.prod_1, rsp_ch.prod_2, rsp_ch.prod_3};
         got.overflow = rsp_ch.overflow;
         if (expected_rows.size() == 0) begin
            $error("product row with none owed: %h", got);
            error_count++;
         end else begin
            want = expected_rows.pop_front();
            for (int i = 0; i < LANES; i++) begin
               if (got.prod[i] !== want.prod[i]) begin
                  $error("prod_%0d: expected %h, got %h", i, want.prod[i], got.prod[i]);
                  error_count++;
               end
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow: expected %b, got %b", want.overflow, got.overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if it outlives the slowest legal schedule by far.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mat4_row_multiply regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      request_type rq;
      int          idle_by_phase  [PHASES];
      int          stall_by_phase [PHASES];
      idle_by_phase  = '{0, 70, 0, 29, 0};
      stall_by_phase = '{0, 0, 70, 29, 0};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_LOAD;
      req_ch.row_sel = '0;
      req_ch.elem_0  = '0;
      req_ch.elem_1  = '0;
      req_ch.elem_2  = '0;
      req_ch.elem_3  = '0;
      right_rows     = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table back to back.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         apply_request(stim_table[i].rq, stim_table[i].typed, stim_table[i].want);
      end

      // Random loads and multiplies; the last phase opens with the long hold-off.
      for (int phase = 0; phase < PHASES; phase++) begin
         req_idle_pct  = idle_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         if (phase == PHASES - 1) hold_off_go = 1'b1;
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            rq.cmd     = ($urandom_range(0, 99) < LOAD_PCT) ? CMD_LOAD : CMD_MULTIPLY;
            rq.row_sel = 2'($urandom_range(0, 3));
            for (int k = 0; k < LANES; k++) begin
               // Mostly small magnitudes so sums stay in range; extremes clip.
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: rq.elem[k] = W'($urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN);
                  4, 5:       rq.elem[k] = W'($urandom);
                  6:          rq.elem[k] = Q_MAX;
                  7:          rq.elem[k] = Q_MIN;
                  default: begin
                     case ($urandom_range(0, 4))
                        0:       rq.elem[k] = Q_ZERO;
                        1:       rq.elem[k] = Q_LSB;
                        2:       rq.elem[k] = Q_NEG1;
                        3:       rq.elem[k] = Q_NEG_ONE;
                        default: rq.elem[k] = Q_ONE;
                     endcase
                  end
               endcase
            end
            apply_request(rq, 1'b0, NO_ROW);
         end
      end

      // Drain: stop offering, release the receiver and wait for every row.
      req_ch.valid  <= 1'b0;
      rsp_stall_pct = 0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("mat4_row_multiply regression: pass");
      end else begin
         $display("mat4_row_multiply regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mrm_pkg.sv
rtl/mrm_req_if.sv
rtl/mrm_rsp_if.sv
rtl/mrm_mul_stage.sv
rtl/mrm_sum_stage.sv
rtl/mrm_sat_stage.sv
rtl/mat4_row_multiply.sv
verif/mat4_row_multiply_tb.sv
